// ===== hw/rtl/esd_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } esd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } esd_out_t;

    // Decoded bytes of one input transaction, oldest in slot 0.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } esd_group_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } esd_hex_t;

    function automatic esd_hex_t hex_value(input logic [7:0] b);
        esd_hex_t r;
        r.hit   = 1'b1;
        r.value = 4'h0;
        case (b) inside
            [8'h30:8'h39]: r.value = 4'(b - 8'h30);
            [8'h61:8'h66]: r.value = 4'(b - 8'h61 + 8'd10);
            [8'h41:8'h46]: r.value = 4'(b - 8'h41 + 8'd10);
            default:       r.hit   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/escape_sequence_decoder.sv =====
// Top level of the escape sequence decoder.
// Depends on esd_pkg, esd_front, esd_queue and esd_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes backslash escapes (\n, \r, \t, \xH, \xHH) in a byte stream, one
// line at a time, with a last flag on the final byte in and out. One input
// transaction is taken per cycle; each yields zero to three output bytes,
// and the output side delivers one byte per cycle while a group is queued
// and dec_stall is low. A queue of four decoded groups sits between the
// escape state machine and the serialiser; the input stalls only while
// that queue is full. The decoded bytes of an input transaction are
// registered in the queue and then in the serialiser's output register.

module escape_sequence_decoder import esd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire esd_in_t    byte_data,
    output logic            dec_valid,
    input  wire logic       dec_stall,
    output esd_out_t        dec_data
);

    logic       accept, push, full, pop, head_valid;
    esd_group_t group, head;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    esd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .data   (byte_data),
        .push   (push),
        .group  (group)
    );

    esd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_group   (group),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    esd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .valid      (dec_valid),
        .stall      (dec_stall),
        .data       (dec_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/esd_front.sv =====
// Front end: escape state machine, turns one input transaction into a group.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_front import esd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire esd_in_t    data,
    output logic            push,
    output esd_group_t      group
);

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_X     = 2'd2;
    localparam logic [1:0] MODE_X1    = 2'd3;

    logic [1:0] mode_reg, mode_next;
    logic [3:0] nib_reg, nib_next;
    logic [1:0] cnt;
    logic [2:0][7:0] bytes;
    esd_hex_t   hx;
    logic [7:0] b;
    logic       last;

    always_comb
    begin
        b         = data.in_byte;
        last      = data.in_last;
        hx        = hex_value(b);
        mode_next = mode_reg;
        nib_next  = nib_reg;
        cnt       = 2'd0;
        bytes     = '0;

        unique case (mode_reg)
            MODE_PLAIN:
            begin
                if (b == CH_BACKSLASH && !last)
                    mode_next = MODE_ESC;
                else
                begin
                    bytes[cnt] = b;
                    cnt        = cnt + 2'd1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_PLAIN;
                if (b == CH_N)
                begin
                    bytes[0] = CH_LF;
                    cnt      = 2'd1;
                end
                else if (b == CH_R)
                begin
                    bytes[0] = CH_CR;
                    cnt      = 2'd1;
                end
                else if (b == CH_T)
                begin
                    bytes[0] = CH_TAB;
                    cnt      = 2'd1;
                end
                else if (b == CH_X)
                begin
                    mode_next = MODE_X;
                    if (last)
                    begin
                        bytes[0] = CH_BACKSLASH;
                        bytes[1] = CH_X;
                        cnt      = 2'd2;
                    end
                end
                else
                begin
                    bytes[0] = CH_BACKSLASH;
                    cnt      = 2'd1;
                    if (b == CH_BACKSLASH && !last)
                        mode_next = MODE_ESC;
                    else
                    begin
                        bytes[cnt] = b;
                        cnt        = cnt + 2'd1;
                    end
                end
            end
            MODE_X:
            begin
                if (hx.hit)
                begin
                    nib_next  = hx.value;
                    mode_next = MODE_X1;
                    if (last)
                    begin
                        bytes[0] = {4'h0, hx.value};
                        cnt      = 2'd1;
                    end
                end
                else
                begin
                    bytes[0]  = CH_BACKSLASH;
                    bytes[1]  = CH_X;
                    cnt       = 2'd2;
                    mode_next = MODE_PLAIN;
                    if (b == CH_BACKSLASH && !last)
                        mode_next = MODE_ESC;
                    else
                    begin
                        bytes[cnt] = b;
                        cnt        = cnt + 2'd1;
                    end
                end
            end
            MODE_X1:
            begin
                mode_next = MODE_PLAIN;
                if (hx.hit)
                begin
                    bytes[0] = {nib_reg, hx.value};
                    cnt      = 2'd1;
                end
                else
                begin
                    bytes[0] = {4'h0, nib_reg};
                    cnt      = 2'd1;
                    if (b == CH_BACKSLASH && !last)
                        mode_next = MODE_ESC;
                    else
                    begin
                        bytes[cnt] = b;
                        cnt        = cnt + 2'd1;
                    end
                end
            end
            default: mode_next = MODE_PLAIN;
        endcase

        if (last)
        begin
            mode_next = MODE_PLAIN;
            nib_next  = 4'h0;
        end
    end

    assign push        = accept && (cnt != 2'd0);
    assign group.bytes = bytes;
    assign group.cnt   = cnt;
    assign group.last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            nib_reg  <= 4'h0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            nib_reg  <= nib_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/esd_queue.sv =====
// Short group queue between front and back ends.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_queue import esd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire esd_group_t wr_group,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output esd_group_t      head
);

    esd_group_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_group;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/esd_back.sv =====
// Back end: serialises queued groups into single output bytes.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_back import esd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire esd_group_t head,
    output logic            pop,
    output logic            valid,
    input  wire logic       stall,
    output esd_out_t        data
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    esd_out_t   data_reg;
    logic       load, final_byte;

    assign load       = head_valid && (!valid_reg || !stall);
    assign final_byte = (idx_reg == head.cnt - 2'd1);
    assign pop        = load && final_byte;
    assign valid      = valid_reg;
    assign data       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (!stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.out_byte <= head.bytes[idx_reg];
            data_reg.out_last <= head.last && final_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/esd_checker.sv =====
// Port-level checks for the escape sequence decoder, bound to the top level.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_checker import esd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic       byte_stall,
    input  wire esd_in_t    byte_data,
    input  wire logic       dec_valid,
    input  wire logic       dec_stall,
    input  wire esd_out_t   dec_data
);

    logic in_txn;
    assign in_txn = byte_valid && !byte_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> dec_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> $stable(dec_data))
        else $error("stalled output payload changed");

    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> dec_valid)
        else $error("input stalled with serialiser idle");

    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dec_valid) |-> $past(in_txn, 2))
        else $error("output appeared without a matching input transaction");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

`default_nettype wire

// ===== tb/escape_sequence_decoder_test.sv =====
// Self-checking testbench for escape_sequence_decoder: directed table, then random lines.
// Depends on esd_pkg and the decoder RTL; output is checked against a model or the table.
`timescale 1ns / 1ps

module escape_sequence_decoder_test;
    import esd_pkg::*;

    typedef enum logic [1:0] {
        DEC_TEXT,
        DEC_ESCAPE,
        DEC_HEX0,
        DEC_HEX1
    } dec_mode_e;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
        logic       typed;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } stim_row_t;

    localparam logic BY_HAND  = 1'b1;
    localparam logic BY_MODEL = 1'b0;
    localparam int   NDIR     = 28;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     byte_valid;
    logic     byte_stall;
    esd_in_t  byte_data;
    logic     dec_valid;
    logic     dec_stall = 1'b0;
    esd_out_t dec_data;

    dec_mode_e  model_mode;
    logic [3:0] model_nibble;
    logic [7:0] grp_bytes [3];
    int         grp_n;
    esd_out_t   decoded_q [$];

    stim_row_t  dir_rows [NDIR];
    int         send_idle;
    int         recv_idle;
    int         hold_left;
    int         items_sent;
    int         lines_done;
    int         bytes_checked;
    int         errors;

    escape_sequence_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .dec_valid  (dec_valid),
        .dec_stall  (dec_stall),
        .dec_data   (dec_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(input string what, input logic [8:0] got, input logic [8:0] want);
        $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        grp_bytes[grp_n] = b;
        grp_n++;
    endtask

    // Decoder model: fills grp_bytes with the bytes one input transaction yields.
    task automatic decode_model(input esd_in_t t);
        logic       is_hex;
        logic [3:0] digit;
        logic       as_text;
        is_hex  = 1'b1;
        digit   = 4'h0;
        as_text = 1'b0;
        grp_n   = 0;
        if (t.in_byte >= 8'h30 && t.in_byte <= 8'h39)
            digit = t.in_byte[3:0];
        else if ((t.in_byte >= 8'h61 && t.in_byte <= 8'h66) ||
                 (t.in_byte >= 8'h41 && t.in_byte <= 8'h46))
            digit = t.in_byte[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        case (model_mode)
            DEC_TEXT:
                as_text = 1'b1;
            DEC_ESCAPE:
            begin
                if (t.in_byte == CH_N)
                begin
                    emit_byte(CH_LF);
                    model_mode = DEC_TEXT;
                end
                else if (t.in_byte == CH_R)
                begin
                    emit_byte(CH_CR);
                    model_mode = DEC_TEXT;
                end
                else if (t.in_byte == CH_T)
                begin
                    emit_byte(CH_TAB);
                    model_mode = DEC_TEXT;
                end
                else if (t.in_byte == CH_X)
                begin
                    if (t.in_last)
                    begin
                        emit_byte(CH_BACKSLASH);
                        emit_byte(CH_X);
                    end
                    model_mode = DEC_HEX0;
                end
                else
                begin
                    emit_byte(CH_BACKSLASH);
                    as_text = 1'b1;
                end
            end
            DEC_HEX0:
            begin
                if (is_hex)
                begin
                    model_nibble = digit;
                    if (t.in_last)
                        emit_byte({4'h0, digit});
                    model_mode = DEC_HEX1;
                end
                else
                begin
                    emit_byte(CH_BACKSLASH);
                    emit_byte(CH_X);
                    as_text = 1'b1;
                end
            end
            default:
            begin
                if (is_hex)
                begin
                    emit_byte({model_nibble, digit});
                    model_mode = DEC_TEXT;
                end
                else
                begin
                    emit_byte({4'h0, model_nibble});
                    as_text = 1'b1;
                end
            end
        endcase

        if (as_text)
        begin
            if (t.in_byte == CH_BACKSLASH && !t.in_last)
                model_mode = DEC_ESCAPE;
            else
            begin
                model_mode = DEC_TEXT;
                emit_byte(t.in_byte);
            end
        end

        if (t.in_last)
        begin
            model_mode   = DEC_TEXT;
            model_nibble = 4'h0;
        end
    endtask

    task automatic queue_decoded(input logic last);
        esd_out_t r;
        for (int i = 0; i < grp_n; i++)
        begin
            r.out_byte = grp_bytes[i];
            r.out_last = last && (i == grp_n - 1);
            decoded_q.push_back(r);
        end
    endtask

    task automatic send_byte(input esd_in_t t);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= t;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        items_sent++;
        if (t.in_last)
            lines_done++;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            dec_stall <= 1'b1;
            hold_left--;
        end
        else
            dec_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin : check_output
        esd_out_t want;
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (decoded_q.size() == 0)
                flag_error("output with nothing expected", dec_data, 9'h0);
            else
            begin
                want = decoded_q.pop_front();
                if (dec_data.out_byte !== want.out_byte)
                    flag_error("out_byte", {1'b0, dec_data.out_byte}, {1'b0, want.out_byte});
                if (dec_data.out_last !== want.out_last)
                    flag_error("out_last", {8'h0, dec_data.out_last}, {8'h0, want.out_last});
            end
            bytes_checked++;
        end
    end

    initial
    begin
        #200000;
        $display("Timeout with %0d decoded bytes outstanding", decoded_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        esd_in_t    t;
        stim_row_t  row;
        logic [7:0] line_q [$];
        logic [7:0] c;
        logic [3:0] v;
        int         goal;
        int         ntok;
        int         ndig;

        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        byte_data     = '0;
        hold_left     = 0;
        send_idle     = 31;
        recv_idle     = 71;
        items_sent    = 0;
        lines_done    = 0;
        bytes_checked = 0;
        errors        = 0;
        model_mode    = DEC_TEXT;
        model_nibble  = 4'h0;

        dir_rows = '{
            {8'h00,        1'b0, BY_HAND,  2'd1, 8'h00,        8'h00, 8'h00},
            {8'hFF,        1'b0, BY_HAND,  2'd1, 8'hFF,        8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_HAND,  2'd0, 8'h00,        8'h00, 8'h00},
            {CH_N,         1'b0, BY_HAND,  2'd1, CH_LF,        8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_HAND,  2'd0, 8'h00,        8'h00, 8'h00},
            {CH_R,         1'b0, BY_HAND,  2'd1, CH_CR,        8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_HAND,  2'd0, 8'h00,        8'h00, 8'h00},
            {CH_T,         1'b0, BY_HAND,  2'd1, CH_TAB,       8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_HAND,  2'd0, 8'h00,        8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_HAND,  2'd1, CH_BACKSLASH, 8'h00, 8'h00},
            {8'h71,        1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {CH_X,         1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {8'h7A,        1'b0, BY_HAND,  2'd3, CH_BACKSLASH, CH_X,  8'h7A},
            {CH_BACKSLASH, 1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {CH_X,         1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {8'h66,        1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {8'h47,        1'b0, BY_HAND,  2'd2, 8'h0F,        8'h47, 8'h00},
            {CH_BACKSLASH, 1'b1, BY_HAND,  2'd1, CH_BACKSLASH, 8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {CH_X,         1'b1, BY_HAND,  2'd2, CH_BACKSLASH, CH_X,  8'h00},
            {CH_BACKSLASH, 1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {CH_X,         1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {8'h41,        1'b1, BY_HAND,  2'd1, 8'h0A,        8'h00, 8'h00},
            {CH_BACKSLASH, 1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {CH_X,         1'b0, BY_MODEL, 2'd0, 8'h00,        8'h00, 8'h00},
            {8'h46,        1'b0, BY_HAND,  2'd0, 8'h00,        8'h00, 8'h00},
            {8'h66,        1'b1, BY_HAND,  2'd1, 8'hFF,        8'h00, 8'h00}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NDIR; i++)
        begin
            row = dir_rows[i];
            t.in_byte = row.b;
            t.in_last = row.l;
            decode_model(t);
            if (row.typed)
            begin
                grp_n        = row.n;
                grp_bytes[0] = row.e0;
                grp_bytes[1] = row.e1;
                grp_bytes[2] = row.e2;
            end
            queue_decoded(t.in_last);
            send_byte(t);
        end

        // Random plain bytes and well-formed escapes, plus broken escapes and noise.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 31;
                    recv_idle = 71;
                end
                1:
                begin
                    send_idle = 71;
                    recv_idle = 31;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    hold_left = 60;
                end
            endcase
            goal = items_sent + 40;
            while (items_sent < goal)
            begin
                line_q.delete();
                ntok = $urandom_range(1, 6);
                for (int k = 0; k < ntok; k++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2:
                        begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (c == CH_BACKSLASH);
                            line_q.push_back(c);
                        end
                        3:
                        begin
                            line_q.push_back(CH_BACKSLASH);
                            case ($urandom_range(0, 2))
                                0:       line_q.push_back(CH_N);
                                1:       line_q.push_back(CH_R);
                                default: line_q.push_back(CH_T);
                            endcase
                        end
                        4, 5:
                        begin
                            line_q.push_back(CH_BACKSLASH);
                            line_q.push_back(CH_X);
                            ndig = $urandom_range(1, 2);
                            for (int d = 0; d < ndig; d++)
                            begin
                                v = 4'($urandom_range(0, 15));
                                if (v < 4'd10)
                                    c = 8'h30 + v;
                                else if ($urandom_range(0, 1))
                                    c = 8'h41 + v - 8'd10;
                                else
                                    c = 8'h61 + v - 8'd10;
                                line_q.push_back(c);
                            end
                        end
                        6:
                        begin
                            line_q.push_back(CH_BACKSLASH);
                            line_q.push_back(8'($urandom_range(0, 255)));
                        end
                        7:
                        begin
                            line_q.push_back(CH_BACKSLASH);
                            line_q.push_back(CH_X);
                            line_q.push_back(8'($urandom_range(0, 255)));
                        end
                        8:
                        begin
                            line_q.push_back(CH_BACKSLASH);
                            line_q.push_back(CH_BACKSLASH);
                        end
                        default:
                            line_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    line_q.push_back(CH_BACKSLASH);
                    if ($urandom_range(0, 1))
                        line_q.push_back(CH_X);
                end
                for (int k = 0; k < line_q.size(); k++)
                begin
                    t.in_byte = line_q[k];
                    t.in_last = (k == line_q.size() - 1);
                    decode_model(t);
                    queue_decoded(t.in_last);
                    send_byte(t);
                end
            end
        end

        @(negedge clk);
        byte_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d input bytes in %0d lines, directed escapes then random ones,",
                 items_sent, lines_done);
        $display("under both idle mixes and a long output hold; %0d decoded bytes checked.",
                 bytes_checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
